/* hw/rtl/pngu_pkg.sv */
// pngu_pkg: shared types and constants of the PNG scanline unfilter.
// Beat structs of both streams, filter codes, register indexes and the
// descriptor that travels from the front to the back. No dependencies.
`timescale 1ns / 1ps

package pngu_pkg;

  // Config register indexes and port widths
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BPP       = 4'd1;

  localparam logic [12:0] ROW_WIDTH_RESET = 13'd1;
  localparam logic [2:0]  BPP_RESET       = 3'd4;

  // Row filter codes; anything above Paeth collapses to FILT_BAD
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_beat_t;

  // One classified sample, front to back (column travels beside it)
  typedef struct packed {
    logic [7:0] data;
    filter_t    filter;
    logic [1:0] lane;       // channel slot of the left / above-left bytes
    logic       first;      // column zero: left context is empty
    logic       last;       // last byte of the row
    logic       first_row;  // no row above: above byte reads as zero
  } desc_t;

endpackage

/* hw/rtl/pngu_front.sv */
// pngu_front: config registers, filter byte capture and column tracking.
// Turns each data beat into a descriptor for the back. Uses pngu_pkg.
`timescale 1ns / 1ps

module pngu_front #(
  parameter int MAX_WIDTH           = 4096,
  parameter int MAX_BYTES_PER_PIXEL = 4,
  parameter int COL_W               = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  // config write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pngu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                         stream_valid,
  output logic                         stream_stall,
  input  pngu_pkg::in_beat_t           stream_beat,
  // descriptor queue side
  input  logic                         q_full,
  output logic                         q_push,
  output pngu_pkg::desc_t              q_desc,
  output logic [COL_W-1:0]             q_col
);

  localparam int DEPTH = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
  localparam int RB_W  = $clog2(DEPTH + 1);
  localparam int W_W   = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;

  logic [12:0]           row_width;
  logic [2:0]            bpp;
  logic                  awaiting;
  logic                  on_first_row;
  pngu_pkg::filter_t     row_filter;
  logic [COL_W-1:0]      col;
  logic [1:0]            k3;          // col mod 3, kept alongside col

  logic [W_W-1:0]        w_ext;
  logic [W_W-1:0]        w_eff;
  logic [RB_W-1:0]       row_bytes;
  logic                  use_four;
  logic                  take;
  logic                  is_filter;
  logic                  first_row_eff;
  logic                  last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= pngu_pkg::ROW_WIDTH_RESET;
      bpp       <= pngu_pkg::BPP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pngu_pkg::REG_ROW_WIDTH: row_width <= cfg_data;
        pngu_pkg::REG_BPP:       bpp       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective row length in bytes: width clamped to 1..MAX_WIDTH, times 3 or 4
  assign use_four = (MAX_BYTES_PER_PIXEL == 4) && (bpp >= 3'd4);

  always_comb begin
    w_ext = W_W'(row_width);
    if (w_ext == '0) begin
      w_eff = W_W'(1);
    end else if (w_ext > W_W'(MAX_WIDTH)) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (use_four) begin
      row_bytes = RB_W'({w_eff, 2'b00});
    end else begin
      row_bytes = RB_W'(w_eff) + RB_W'({w_eff, 1'b0});
    end
  end

  assign stream_stall  = q_full;
  assign take          = stream_valid && !q_full;
  assign is_filter     = stream_beat.start_image || awaiting;
  assign first_row_eff = stream_beat.start_image || on_first_row;
  // col never reaches DEPTH: it only advances while col + 1 < row_bytes
  assign last          = (RB_W'(col) + RB_W'(1)) >= row_bytes;

  assign q_push           = take && !is_filter;
  assign q_col            = col;
  assign q_desc.data      = stream_beat.data_byte;
  assign q_desc.filter    = row_filter;
  assign q_desc.lane      = use_four ? col[1:0] : k3;
  assign q_desc.first     = (col == '0);
  assign q_desc.last      = last;
  assign q_desc.first_row = on_first_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting     <= 1'b1;
      on_first_row <= 1'b1;
      row_filter   <= pngu_pkg::FILT_NONE;
      col          <= '0;
      k3           <= 2'd0;
    end else if (take) begin
      if (is_filter) begin
        awaiting     <= 1'b0;
        on_first_row <= first_row_eff;
        row_filter   <= (stream_beat.data_byte > 8'd4) ? pngu_pkg::FILT_BAD
                        : pngu_pkg::filter_t'(stream_beat.data_byte[2:0]);
        col          <= '0;
        k3           <= 2'd0;
      end else if (last) begin
        awaiting     <= 1'b1;
        on_first_row <= 1'b0;
        col          <= '0;
        k3           <= 2'd0;
      end else begin
        col <= col + COL_W'(1);
        k3  <= (k3 == 2'd2) ? 2'd0 : k3 + 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/pngu_fifo.sv */
// pngu_fifo: four-entry descriptor queue between front and back.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps

module pngu_fifo #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int DEPTH = 4;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       count;

  assign full      = (count == 3'(DEPTH));
  assign not_empty = (count != 3'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/pngu_back.sv */
// pngu_back: line buffer read, reconstruction and output register.
// Pops descriptors, applies None/Sub/Up/Average/Paeth. Uses pngu_pkg.
`timescale 1ns / 1ps

module pngu_back #(
  parameter int DEPTH = 16384,
  parameter int COL_W = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  pngu_pkg::desc_t      q_desc,
  input  logic [COL_W-1:0]     q_col,
  output logic                 q_pop,
  output logic                 pix_valid,
  input  logic                 pix_stall,
  output pngu_pkg::out_beat_t  pix_beat
);

  logic [7:0]        prior_row [DEPTH];
  logic [7:0]        above_raw;
  logic              s1_valid;
  pngu_pkg::desc_t   s1_desc;
  logic [COL_W-1:0]  s1_col;
  logic [7:0]        left_bytes [4];
  logic [7:0]        above_left_bytes [4];

  logic              advance;
  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        sum_ab;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [9:0]        diff_bc;
  logic [9:0]        diff_ac;
  logic [9:0]        diff_p;
  logic [7:0]        pred;
  logic [7:0]        recon;

  assign advance = s1_valid && (!pix_valid || !pix_stall);
  assign q_pop   = q_not_empty && (!s1_valid || advance);

  // Line buffer: read on pop, written as the sample commits. The same column
  // is read again a full row later (a row is at least three bytes), so no bypass.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      above_raw <= prior_row[q_col];
    end
    if (advance) begin
      prior_row[s1_col] <= recon;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_desc <= q_desc;
      s1_col  <= q_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Predictor inputs: empty left context at column zero, no row above on the first row
  always_comb begin
    a = s1_desc.first ? 8'd0 : left_bytes[s1_desc.lane];
    c = s1_desc.first ? 8'd0 : above_left_bytes[s1_desc.lane];
    b = s1_desc.first_row ? 8'd0 : above_raw;
    sum_ab  = {1'b0, a} + {1'b0, b};
    // p = a + b - c; pa = |p - a| = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    diff_bc = {2'b00, b} - {2'b00, c};
    diff_ac = {2'b00, a} - {2'b00, c};
    diff_p  = {1'b0, sum_ab} - {1'b0, c, 1'b0};
    pa = diff_bc[9] ? (~diff_bc + 10'd1) : diff_bc;
    pb = diff_ac[9] ? (~diff_ac + 10'd1) : diff_ac;
    pc = diff_p[9]  ? (~diff_p + 10'd1)  : diff_p;
    case (s1_desc.filter)
      pngu_pkg::FILT_SUB: pred = a;
      pngu_pkg::FILT_UP:  pred = b;
      pngu_pkg::FILT_AVG: pred = sum_ab[8:1];
      pngu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: pred = 8'd0;
    endcase
    recon = s1_desc.data + pred;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        if (2'(i) == s1_desc.lane) begin
          left_bytes[i]       <= recon;
          above_left_bytes[i] <= b;
        end else if (s1_desc.first) begin
          left_bytes[i]       <= 8'd0;
          above_left_bytes[i] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_beat.pixel_byte <= recon;
      pix_beat.row_end    <= s1_desc.last;
      pix_beat.bad_filter <= (s1_desc.filter == pngu_pkg::FILT_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/png_scanline_unfilter.sv */
// png_scanline_unfilter: PNG row unfilter for 8-bit RGB / RGBA, one byte a beat.
// Throughput: one input beat per cycle while the queue is not full; filter
// type bytes produce no output. A data byte is written to the queue at the
// accepting edge, then passes the line buffer read stage and the output
// register on its way to pix_*.
// Reset (rst, synchronous): stream state back to "awaiting filter byte" on a
// first row; line buffer contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
  parameter int MAX_WIDTH           = 4096,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // Config write channel: index 0 row width in pixels, index 1 bytes/pixel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pngu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Inflated byte stream in
  input  logic                             stream_valid,
  output logic                             stream_stall,
  input  pngu_pkg::in_beat_t               stream_beat,
  // Reconstructed bytes out
  output logic                             pix_valid,
  input  logic                             pix_stall,
  output pngu_pkg::out_beat_t              pix_beat
);

  // Line buffer holds one full row at the widest setting
  localparam int DEPTH  = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
  localparam int COL_W  = $clog2(DEPTH);
  localparam int DESC_W = $bits(pngu_pkg::desc_t);
  localparam int ENTRY_W = DESC_W + COL_W;

  pngu_pkg::desc_t    f_desc;
  logic [COL_W-1:0]   f_col;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_not_empty;
  logic [ENTRY_W-1:0] q_head;
  pngu_pkg::desc_t    b_desc;
  logic [COL_W-1:0]   b_col;

  // Front: captures each row's filter byte, counts columns, tags every data
  // beat with its lane (column mod pixel size), row-end and first-row flags.
  // It stalls the input only when the queue is full.
  pngu_front #(
    .MAX_WIDTH           (MAX_WIDTH),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL),
    .COL_W               (COL_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_beat  (stream_beat),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (f_desc),
    .q_col        (f_col)
  );

  // Short queue so a stalled output does not immediately back up the input
  pngu_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_desc, f_col}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .not_empty (q_not_empty)
  );

  assign b_desc = pngu_pkg::desc_t'(q_head[ENTRY_W-1:COL_W]);
  assign b_col  = q_head[COL_W-1:0];

  // Back: reads the above byte from the line buffer, rebuilds the sample,
  // writes it back for the next row and holds it in the output register.
  pngu_back #(
    .DEPTH (DEPTH),
    .COL_W (COL_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_desc      (b_desc),
    .q_col       (b_col),
    .q_pop       (q_pop),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pix_beat    (pix_beat)
  );

endmodule
